// ===== src/ifsc_pkg.sv =====
// Shared types, constants and a helper function for the IMU frame decoder.
`timescale 1ns / 1ps

package ifsc_pkg;

  // Default frame length in bytes, including header and checksum.
  localparam int FRAME_BYTES_DEF = 11;

  // Depth of the queue between the frame checker and the output stage.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int OFFSET_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_OFFSET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_COMMAND  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_COMMAND   = 8'd3;

  // Register reset values.
  localparam logic [7:0]          HEADER_BYTE_RST    = 8'd85;
  localparam logic [OFFSET_W-1:0] COMMAND_OFFSET_RST = 4'd1;
  localparam logic [7:0]          ANGLE_COMMAND_RST  = 8'd83;
  localparam logic [7:0]          QUAT_COMMAND_RST   = 8'd89;

  // Frame kind codes as they appear on the output.
  localparam logic KIND_ANGLE = 1'b0;
  localparam logic KIND_QUAT  = 1'b1;

  // One decoded frame waiting for the output stage: raw little-endian words
  // taken from frame bytes 2..3, 4..5, 6..7 and 8..9.
  typedef struct packed {
    logic        kind;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
  } frame_entry_t;

  // Degrees times 128 from a raw angle word: floor(raw * 180 / 256).
  // The product fits in 24 bits, and taking its upper 16 bits floors it.
  function automatic logic [15:0] deg128(input logic [15:0] raw);
    logic [23:0] prod;
    prod = {{8{raw[15]}}, raw} * 24'd180;
    return prod[23:8];
  endfunction

endpackage

// ===== src/ifsc_front.sv =====
// Frame checker: byte window, running checksum, resync count and command decode.
`timescale 1ns / 1ps

module ifsc_front #(
  parameter int FrameBytes = ifsc_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ifsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ifsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             push_o,
  output ifsc_pkg::frame_entry_t           push_data_o,
  input  logic                             queue_full_i
);

  localparam int CntW = $clog2(FrameBytes + 1);
  localparam int WinW = $clog2(FrameBytes);

  logic [7:0]                    header_q;
  logic [ifsc_pkg::OFFSET_W-1:0] offset_q;
  logic [7:0]                    angle_cmd_q;
  logic [7:0]                    quat_cmd_q;

  logic [7:0]      win_q [FrameBytes];
  logic [7:0]      win_d [FrameBytes];
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;

  logic            accept;
  logic            frame_ok;
  logic            cmd_valid;
  logic [WinW-1:0] cmd_idx;
  logic [7:0]      cmd_byte;
  logic            is_angle;
  logic            is_quat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= ifsc_pkg::HEADER_BYTE_RST;
      offset_q    <= ifsc_pkg::COMMAND_OFFSET_RST;
      angle_cmd_q <= ifsc_pkg::ANGLE_COMMAND_RST;
      quat_cmd_q  <= ifsc_pkg::QUAT_COMMAND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ifsc_pkg::CFG_HEADER_BYTE:    header_q    <= cfg_data_i[7:0];
        ifsc_pkg::CFG_COMMAND_OFFSET: offset_q    <= cfg_data_i[ifsc_pkg::OFFSET_W-1:0];
        ifsc_pkg::CFG_ANGLE_COMMAND:  angle_cmd_q <= cfg_data_i[7:0];
        ifsc_pkg::CFG_QUAT_COMMAND:   quat_cmd_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Window after the incoming byte is shifted in, oldest byte first.
  always_comb begin
    for (int i = 0; i < FrameBytes - 1; i++) begin
      win_d[i] = win_q[i + 1];
    end
    win_d[FrameBytes - 1] = rx_byte_i;
  end

  // The sum covers all window bytes but the last. Sliding the window drops the
  // oldest byte from the sum and brings in the byte that was last before.
  assign sum_d   = sum_q - win_q[0] + win_q[FrameBytes - 1];
  assign cnt_inc = (cnt_q < CntW'(FrameBytes)) ? cnt_q + 1'b1 : cnt_q;

  assign frame_ok = (cnt_inc == CntW'(FrameBytes)) && (win_d[0] == header_q) &&
                    (sum_d == rx_byte_i);

  assign cmd_valid = (int'(offset_q) < FrameBytes);
  assign cmd_idx   = WinW'(offset_q);
  assign cmd_byte  = cmd_valid ? win_d[cmd_idx] : 8'd0;
  assign is_angle  = cmd_valid && (cmd_byte == angle_cmd_q);
  assign is_quat   = cmd_valid && (cmd_byte == quat_cmd_q);

  // An accepted frame clears the count whether or not it yields an item.
  assign cnt_d = frame_ok ? '0 : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < FrameBytes; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      for (int i = 0; i < FrameBytes; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  assign push_o            = accept && frame_ok && (is_angle || is_quat);
  assign push_data_o.kind  = is_angle ? ifsc_pkg::KIND_ANGLE : ifsc_pkg::KIND_QUAT;
  assign push_data_o.word0 = {win_d[3], win_d[2]};
  assign push_data_o.word1 = {win_d[5], win_d[4]};
  assign push_data_o.word2 = {win_d[7], win_d[6]};
  assign push_data_o.word3 = {win_d[9], win_d[8]};

endmodule

// ===== src/ifsc_queue.sv =====
// Small register queue of decoded frames between the checker and the output stage.
`timescale 1ns / 1ps

module ifsc_queue #(
  parameter int Depth = ifsc_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ifsc_pkg::frame_entry_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output ifsc_pkg::frame_entry_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ifsc_pkg::frame_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/ifsc_back.sv =====
// Output stage: scales angle words or passes quaternion words into the result register.
`timescale 1ns / 1ps

module ifsc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  ifsc_pkg::frame_entry_t q_data_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   frame_kind_o,
  output logic signed [15:0]     roll_deg_o,
  output logic signed [15:0]     pitch_deg_o,
  output logic signed [15:0]     yaw_deg_o,
  output logic signed [15:0]     quat_w_o,
  output logic signed [15:0]     quat_z_o,
  output logic signed [15:0]     quat_x_o,
  output logic signed [15:0]     quat_y_o
);

  logic        valid_q;
  logic        load;
  logic        is_angle;
  logic [15:0] roll_d, pitch_d, yaw_d;

  // The result register takes a new item whenever it is empty or being taken.
  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = load;

  assign is_angle = (q_data_i.kind == ifsc_pkg::KIND_ANGLE);
  assign roll_d   = ifsc_pkg::deg128(q_data_i.word0);
  assign pitch_d  = 16'(-ifsc_pkg::deg128(q_data_i.word1));
  assign yaw_d    = ifsc_pkg::deg128(q_data_i.word2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_kind_o <= q_data_i.kind;
      roll_deg_o   <= is_angle ? roll_d  : 16'sd0;
      pitch_deg_o  <= is_angle ? pitch_d : 16'sd0;
      yaw_deg_o    <= is_angle ? yaw_d   : 16'sd0;
      quat_w_o     <= is_angle ? 16'sd0 : q_data_i.word0;
      quat_z_o     <= is_angle ? 16'sd0 : q_data_i.word1;
      quat_x_o     <= is_angle ? 16'sd0 : q_data_i.word2;
      quat_y_o     <= is_angle ? 16'sd0 : q_data_i.word3;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== src/imu_frame_sync_checksum_decoder_top.sv =====
// Top level of the IMU serial frame decoder.
`timescale 1ns / 1ps

// Takes one received serial byte per clock cycle, unless stalled, and checks every
// full window of FrameBytes bytes for a header byte, an 8-bit additive checksum in
// the last byte and at least a frame's worth of bytes since the previous accepted
// frame. Angle frames give three angles in degrees times 128 and quaternion frames
// four Q15 words; other accepted frames give no item. The checksum is kept as a
// running sum, so the check costs one add and compare per byte. A result item is
// pushed into a two-entry queue when the frame's last byte is taken and loaded
// from there into the output register; the queue keeps bytes flowing while the
// output is stalled, and the input stalls only once the queue is full. Configuration
// writes are always ready and take effect on the next byte.

module imu_frame_sync_checksum_decoder_top #(
  parameter int FrameBytes = ifsc_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ifsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ifsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            frame_kind_o,
  output logic signed [15:0]              roll_deg_o,
  output logic signed [15:0]              pitch_deg_o,
  output logic signed [15:0]              yaw_deg_o,
  output logic signed [15:0]              quat_w_o,
  output logic signed [15:0]              quat_z_o,
  output logic signed [15:0]              quat_x_o,
  output logic signed [15:0]              quat_y_o
);

  logic                   push;
  ifsc_pkg::frame_entry_t push_data;
  logic                   queue_full;
  logic                   q_valid;
  ifsc_pkg::frame_entry_t q_data;
  logic                   q_pop;

  ifsc_front #(
    .FrameBytes(FrameBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .queue_full_i(queue_full)
  );

  ifsc_queue #(
    .Depth(ifsc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (queue_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  ifsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_kind_o(frame_kind_o),
    .roll_deg_o  (roll_deg_o),
    .pitch_deg_o (pitch_deg_o),
    .yaw_deg_o   (yaw_deg_o),
    .quat_w_o    (quat_w_o),
    .quat_z_o    (quat_z_o),
    .quat_x_o    (quat_x_o),
    .quat_y_o    (quat_y_o)
  );

endmodule
